### hdl/scq_pkg.sv
// scq_pkg: shared types and constants for the searchable circular queue
// holds depth, field widths, operation and status codes, and cell control types
// no dependencies
package scq_pkg;

  // queue depth and derived widths
  localparam int unsigned DEPTH = 128;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned GRP_W  = 8;
  localparam int unsigned STAT_W = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_SEARCH = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REPLY
  } scq_state_t;

  // one stored entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [GRP_W-1:0] grp;
  } entry_t;

  // per-cycle command to the cell row
  typedef struct packed {
    logic load;    // write new entry into the cell at position count
    logic shift;   // every cell takes its upper neighbor (pop)
    logic rotate;  // occupied cells turn by one, last takes the head
  } cell_ctrl_t;

endpackage

### hdl/searchable_circular_queue.sv
// searchable_circular_queue: top level of the searchable FIFO queue
// control sequencer, fill count and output register around the cell row
// depends on scq_pkg, scq_chain
//
// usage
//   input channel in_valid / in_stall carries one operation per item:
//   push (item id, group id), pop, or search (item id is the key).
//   result channel out_valid / out_stall returns exactly one item per input
//   item: status, popped item id and group id.
//   the queue is a row of DEPTH cells with the oldest entry in cell zero.
//   push writes the cell at the fill count, pop shifts the row down by one.
//   push, pop, unused code and any empty case load the output register in
//   the cycle that accepts them. a search over n held entries turns the
//   occupied cells once around through cell zero, one cell per cycle, then
//   loads the result from the reply state once the output register is free.
//   throughput: one item per cycle for push and pop while results are taken;
//   a search holds off new items until its result is loaded.
//   a new item is accepted while a result waits in the output register only
//   if that result is taken in the same cycle.
//   reset (rst_n low, synchronous) empties the queue and drops any result.
//   a stalled result holds its value until taken; in_stall stays high.
module searchable_circular_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [scq_pkg::FUNC_W-1:0] in_func,
  input  logic [scq_pkg::ID_W-1:0]   in_item_id,
  input  logic [scq_pkg::GRP_W-1:0]  in_group_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [scq_pkg::STAT_W-1:0] out_status,
  output logic [scq_pkg::ID_W-1:0]   out_item_id,
  output logic [scq_pkg::GRP_W-1:0]  out_group_id
);
  import scq_pkg::*;

  scq_state_t       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic [ID_W-1:0]  key_r, key_nxt;
  logic             found_r, found_nxt;
  logic [GRP_W-1:0] fgrp_r, fgrp_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [GRP_W-1:0] out_grp_r, out_grp_nxt;

  cell_ctrl_t       ctrl;
  entry_t           din;
  entry_t           head;
  logic             out_free;
  logic             accept;
  logic             out_load;
  func_t            func;

  // cell row
  scq_chain u_chain (
    .clk   (clk),
    .count (count_r),
    .ctrl  (ctrl),
    .din   (din),
    .head  (head)
  );

  assign din.id  = in_item_id;
  assign din.grp = in_group_id;
  assign func    = func_t'(in_func);

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // next state and cell commands
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    fgrp_nxt       = fgrp_r;
    ctrl           = '0;
    out_load       = 1'b0;
    out_status_nxt = STAT_OK;
    out_id_nxt     = '0;
    out_grp_nxt    = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_PUSH: begin
              out_load = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ctrl.load = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            FN_POP: begin
              out_load = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_id_nxt  = head.id;
                out_grp_nxt = head.grp;
                ctrl.shift  = 1'b1;
                count_nxt   = count_r - CW'(1);
              end
            end
            FN_SEARCH: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                key_nxt   = in_item_id;
                found_nxt = 1'b0;
                fgrp_nxt  = '0;
                step_nxt  = '0;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // look at the head, then turn the occupied cells by one
        ctrl.rotate = 1'b1;
        if (!found_r && (head.id == key_r)) begin
          found_nxt = 1'b1;
          fgrp_nxt  = head.grp;
        end
        step_nxt = step_r + CW'(1);
        if (step_r == (count_r - CW'(1))) begin
          state_nxt = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = found_r ? STAT_OK : STAT_NOTFOUND;
          out_grp_nxt    = found_r ? fgrp_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search and result payload registers
  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    fgrp_r  <= fgrp_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_grp_r    <= out_grp_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_item_id  = out_id_r;
  assign out_group_id = out_grp_r;

endmodule

### hdl/scq_cell.sv
// scq_cell: one storage cell of the queue row
// holds one entry, loads, shifts or rotates it under a shared command
// depends on scq_pkg
module scq_cell (
  input  logic                   clk,
  input  logic [scq_pkg::IW-1:0] idx,
  input  logic [scq_pkg::CW-1:0] count,
  input  scq_pkg::cell_ctrl_t    ctrl,
  input  scq_pkg::entry_t        din,
  input  scq_pkg::entry_t        nb,
  input  scq_pkg::entry_t        wrap,
  output scq_pkg::entry_t        q
);
  import scq_pkg::*;

  entry_t data_r;
  entry_t data_nxt;
  logic   is_tail;
  logic   is_last;

  // position of this cell against the fill level
  assign is_tail = (CW'(idx) == count);
  assign is_last = ((CW'(idx) + CW'(1)) == count);

  // next content of the cell
  always_comb begin
    data_nxt = data_r;
    if (ctrl.load && is_tail) begin
      data_nxt = din;
    end else if (ctrl.shift) begin
      data_nxt = nb;
    end else if (ctrl.rotate) begin
      data_nxt = is_last ? wrap : nb;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

### hdl/scq_chain.sv
// scq_chain: row of DEPTH cells, oldest entry in cell zero whenever no search is turning the row
// wires each cell to its upper neighbor and to the head for wrap-around
// depends on scq_pkg, scq_cell
module scq_chain (
  input  logic                   clk,
  input  logic [scq_pkg::CW-1:0] count,
  input  scq_pkg::cell_ctrl_t    ctrl,
  input  scq_pkg::entry_t        din,
  output scq_pkg::entry_t        head
);
  import scq_pkg::*;

  entry_t q [DEPTH];

  // cell row, top cell takes the head as its neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    scq_cell u_cell (
      .clk   (clk),
      .idx   (IW'(i)),
      .count (count),
      .ctrl  (ctrl),
      .din   (din),
      .nb    (q[(i + 1) % DEPTH]),
      .wrap  (q[0]),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

### hdl/scq_checker.sv
// scq_checker: port-level checks for the searchable circular queue
// bound to the top level; depends on scq_pkg
module scq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [scq_pkg::FUNC_W-1:0] in_func,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [scq_pkg::STAT_W-1:0] out_status,
  input logic [scq_pkg::ID_W-1:0]   out_item_id,
  input logic [scq_pkg::GRP_W-1:0]  out_group_id
);
  import scq_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_item_id) && $stable(out_group_id))
    else $error("stalled result changed");

  // no item taken while a result sits stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("item accepted over a stalled result");

  // push and pop answer in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FN_PUSH || in_func == FN_POP) |=> out_valid)
    else $error("push or pop result late");

  // failed operations carry no item id and no group id
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL || out_status == STAT_EMPTY
      || out_status == STAT_NOTFOUND) |-> out_item_id == '0 && out_group_id == '0)
    else $error("nonzero fields on failed operation");

endmodule

bind searchable_circular_queue scq_checker u_scq_checker (.*);

### sim/testbench.sv
// testbench for searchable_circular_queue: random push, pop and search traffic
// checked item by item against a queue predictor held in a small scoreboard class
// depends on scq_pkg and searchable_circular_queue
`timescale 1ns / 1ps

module testbench;
  import scq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT = DEPTH + 12;
  localparam int unsigned HOLD_OFF   = 400;
  localparam int unsigned HOLD_AFTER = 500;
  localparam int unsigned ROUNDS     = 5;

  // one expected reply
  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  item_id;
    logic [GRP_W-1:0] group_id;
  } reply_t;

  // queue predictor and store of expected replies
  class queue_scoreboard;
    logic [ID_W-1:0]  held_ids[DEPTH];
    logic [GRP_W-1:0] held_groups[DEPTH];
    int unsigned      head_pos;
    int unsigned      tail_pos;
    int unsigned      fill;
    reply_t           expected_replies[$];
    int unsigned      errors;

    function new();
      head_pos = 0;
      tail_pos = 0;
      fill     = 0;
      errors   = 0;
    endfunction

    // apply one accepted item to the predicted queue and note its reply
    function void note_item(func_t op, logic [ID_W-1:0] id, logic [GRP_W-1:0] grp);
      reply_t      r;
      int unsigned pos;
      r.status   = STAT_OK;
      r.item_id  = '0;
      r.group_id = '0;
      case (op)
        FN_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            held_ids[tail_pos]    = id;
            held_groups[tail_pos] = grp;
            tail_pos = (tail_pos + 1 >= DEPTH) ? 0 : tail_pos + 1;
            fill++;
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.item_id  = held_ids[head_pos];
            r.group_id = held_groups[head_pos];
            head_pos = (head_pos + 1 >= DEPTH) ? 0 : head_pos + 1;
            fill--;
          end
        end
        FN_SEARCH: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            // oldest entry first, first match wins
            r.status = STAT_NOTFOUND;
            pos = head_pos;
            for (int unsigned k = 0; k < fill; k++) begin
              if (held_ids[pos] == id) begin
                r.status   = STAT_OK;
                r.group_id = held_groups[pos];
                break;
              end
              pos = (pos + 1 >= DEPTH) ? 0 : pos + 1;
            end
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    // compare one accepted result with the oldest expected reply
    function void check_result(logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                               logic [GRP_W-1:0] grp);
      reply_t r;
      if (expected_replies.size() == 0) begin
        $error("out_status: unexpected result, got %0d", st);
        errors++;
        return;
      end
      r = expected_replies.pop_front();
      if (st !== r.status) begin
        $error("out_status: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (id !== r.item_id) begin
        $error("out_item_id: expected %0h, got %0h", r.item_id, id);
        errors++;
      end
      if (grp !== r.group_id) begin
        $error("out_group_id: expected %0h, got %0h", r.group_id, grp);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func;
  logic [ID_W-1:0]    in_item_id;
  logic [GRP_W-1:0]   in_group_id;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  out_status;
  logic [ID_W-1:0]    out_item_id;
  logic [GRP_W-1:0]   out_group_id;

  queue_scoreboard    sb = new();
  bit                 send_burst;
  bit                 take_burst;
  logic [ID_W-1:0]    recent_ids[$];
  int unsigned        idle_cycles;

  searchable_circular_queue u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_item_id   (in_item_id),
    .in_group_id  (in_group_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_item_id  (out_item_id),
    .out_group_id (out_group_id)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // draw the wait before an item, with runs of back-to-back items
  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(63) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(18);
  endfunction

  // offer one item and hold it until it is accepted
  task automatic send_item(input func_t op, input logic [ID_W-1:0] id,
                           input logic [GRP_W-1:0] grp);
    int unsigned gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= op;
    in_item_id  <= id;
    in_group_id <= grp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // pick an operation from percentages, with a rare unused code
  function automatic func_t pick_op(int unsigned push_pct, int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return FN_PUSH;
    if (r < push_pct + pop_pct) return FN_POP;
    if (r < 98) return FN_SEARCH;
    return FN_NONE;
  endfunction

  // one random item; ids often repeat so searches hit and find first matches
  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct);
    func_t           op;
    logic [ID_W-1:0] id;
    int unsigned     r;
    op = pick_op(push_pct, pop_pct);
    r  = $urandom_range(99);
    if (op == FN_SEARCH && r < 60 && recent_ids.size() > 0)
      id = recent_ids[$urandom_range(recent_ids.size() - 1)];
    else if (r < 80)
      id = ID_W'($urandom_range(7));
    else
      id = ID_W'($urandom_range(16'hffff));
    if (op == FN_PUSH) begin
      recent_ids.push_back(id);
      if (recent_ids.size() > 32) void'(recent_ids.pop_front());
    end
    send_item(op, id, GRP_W'($urandom_range(8'hff)));
  endtask

  // stimulus: reset, directed cases, then fill / mix / drain rounds
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = FN_PUSH;
    in_item_id  = '0;
    in_group_id = '0;
    send_burst  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue cases and the unused code
    send_item(FN_POP, 16'h0000, 8'h00);
    send_item(FN_SEARCH, 16'h0000, 8'h00);
    send_item(FN_NONE, 16'h0000, 8'h00);
    // field extremes and a duplicate id
    send_item(FN_PUSH, 16'hffff, 8'hff);
    send_item(FN_PUSH, 16'h0000, 8'h00);
    send_item(FN_PUSH, 16'h0005, 8'h11);
    send_item(FN_PUSH, 16'h0005, 8'h22);
    send_item(FN_SEARCH, 16'h0005, 8'hff);
    send_item(FN_SEARCH, 16'hffff, 8'h00);
    send_item(FN_SEARCH, 16'h0000, 8'h00);
    send_item(FN_SEARCH, 16'h1234, 8'h00);
    send_item(FN_NONE, 16'hffff, 8'hff);
    send_item(FN_POP, 16'hffff, 8'hff);
    send_item(FN_SEARCH, 16'hffff, 8'h00);
    send_item(FN_POP, 16'h0000, 8'h00);
    send_item(FN_SEARCH, 16'h0005, 8'h00);
    send_item(FN_POP, 16'h0000, 8'h00);
    send_item(FN_POP, 16'h0000, 8'h00);
    send_item(FN_POP, 16'h0000, 8'h00);
    send_item(FN_SEARCH, 16'h0005, 8'h00);

    // fill past full, mix, then drain past empty
    for (int unsigned rnd = 0; rnd < ROUNDS; rnd++) begin
      repeat (170) send_random(88, 5);
      repeat (30) send_random(35, 30);
      repeat (170) send_random(5, 88);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off so the queue backs up
  initial begin
    int unsigned gap;
    int unsigned taken;
    out_stall  = 1'b0;
    take_burst = 1'b0;
    taken      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        gap = draw_gap(take_burst);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      taken++;
    end
  end

  // note accepted items and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_item(func_t'(in_func), in_item_id, in_group_id);
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_item_id, out_group_id);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
